// ===== rtl/aac_pkg.sv =====
package aac_pkg;

   localparam int AccelWidth   = 16;
   localparam int TimeWidth    = 32;
   localparam int CountWidth   = 16;
   localparam int DevWidth     = 16;
   localparam int CsrDataWidth = 32;
   localparam int CsrIndexWidth = 3;
   localparam int RootSteps    = 16;
   localparam int PctScale     = 100;

   localparam int AvgDepthDefault = 10;

   localparam logic [14:0] OneGReset          = 15'd8192;
   localparam logic [15:0] RestLimitReset     = 16'd819;
   localparam logic [15:0] RunLimitReset      = 16'd4096;
   localparam logic [31:0] WindowMsReset      = 32'd300000;
   localparam logic [6:0]  ActivePercentReset = 7'd70;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ONE_G          = 3'd0,
      CSR_REST_LIMIT     = 3'd1,
      CSR_RUN_LIMIT      = 3'd2,
      CSR_WINDOW_MS      = 3'd3,
      CSR_ACTIVE_PERCENT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_REST = 2'd0,
      ACT_WALK = 2'd1,
      ACT_RUN  = 2'd2
   } activity_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DEVIATE,
      ST_CLASSIFY,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic     load;
      logic     square;
      axis_type axis;
      logic     root_step;
      logic     deviate;
      logic     classify;
      logic     reply;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/aac_ctrl.sv =====
module aac_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  aac_pkg::status_type status,
   output aac_pkg::cmd_type    cmd
);
   import aac_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.axis      = axis_type'(step_ff[1:0]);
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            if (step_ff[1:0] == AXIS_Z) begin
               step_in  = '0;
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 4'd1;
            if (step_ff == 4'(RootSteps - 1)) begin
               state_in = ST_DEVIATE;
            end
         end
         ST_DEVIATE: begin
            cmd.deviate = 1'b1;
            state_in    = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = ST_REPLY;
         end
         ST_REPLY: begin
            if (status.out_free) begin
               cmd.reply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/aac_datapath.sv =====
module aac_datapath #(
   parameter int AVG_DEPTH = aac_pkg::AvgDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  aac_pkg::cmd_type                  cmd,
   output aac_pkg::status_type               status,
   input  logic signed [15:0]                req_accel_x,
   input  logic signed [15:0]                req_accel_y,
   input  logic signed [15:0]                req_accel_z,
   input  logic [31:0]                       req_time_ms,
   input  logic                              csr_write,
   input  logic [aac_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [aac_pkg::CsrDataWidth-1:0]  csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_activity,
   output logic                              rsp_window_done,
   output logic                              rsp_window_active,
   output logic [15:0]                       rsp_active_count,
   output logic [15:0]                       rsp_total_count
);
   import aac_pkg::*;

   localparam int SumWidth = DevWidth + $clog2(AVG_DEPTH);
   localparam int PosWidth = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int PctWidth = 23;

   // configuration
   logic [14:0] one_g_ff;
   logic [15:0] rest_limit_ff;
   logic [15:0] run_limit_ff;
   logic [31:0] window_ms_ff;
   logic [6:0]  active_percent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_g_ff          <= OneGReset;
         rest_limit_ff     <= RestLimitReset;
         run_limit_ff      <= RunLimitReset;
         window_ms_ff      <= WindowMsReset;
         active_percent_ff <= ActivePercentReset;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ONE_G:          one_g_ff          <= csr_data[14:0];
            CSR_REST_LIMIT:     rest_limit_ff     <= csr_data[15:0];
            CSR_RUN_LIMIT:      run_limit_ff      <= csr_data[15:0];
            CSR_WINDOW_MS:      window_ms_ff      <= csr_data[31:0];
            CSR_ACTIVE_PERCENT: active_percent_ff <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   // captured beat
   logic signed [AccelWidth-1:0] ax_ff, ay_ff, az_ff;
   logic [TimeWidth-1:0]         time_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= req_accel_x;
         ay_ff   <= req_accel_y;
         az_ff   <= req_accel_z;
         time_ff <= req_time_ms;
      end
   end

   // sum of squares, then bit-serial square root
   logic signed [AccelWidth-1:0] axis_sel;
   logic signed [31:0]           sq_term;
   logic [31:0]                  rem_ff, rem_in;
   logic [31:0]                  root_ff, root_in;
   logic [31:0]                  bit_ff, bit_in;
   logic [32:0]                  trial;

   always_comb begin
      case (cmd.axis)
         AXIS_X:  axis_sel = ax_ff;
         AXIS_Y:  axis_sel = ay_ff;
         AXIS_Z:  axis_sel = az_ff;
         default: axis_sel = az_ff;
      endcase
   end

   assign sq_term = axis_sel * axis_sel;
   assign trial   = {1'b0, root_ff} + {1'b0, bit_ff};

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.load) begin
         rem_in  = '0;
         root_in = '0;
         bit_in  = 32'h4000_0000;
      end else if (cmd.square) begin
         rem_in = rem_ff + unsigned'(sq_term);
      end else if (cmd.root_step) begin
         bit_in = bit_ff >> 2;
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[31:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   // deviation ring and running sum
   logic [DevWidth-1:0] ring_ff [AVG_DEPTH];
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [SumWidth-1:0] sum_ff, sum_in;
   logic [DevWidth-1:0] mag;
   logic [DevWidth-1:0] dev;
   logic [DevWidth-1:0] one_g_ext;

   assign mag       = root_ff[DevWidth-1:0];
   assign one_g_ext = {1'b0, one_g_ff};
   assign dev       = (mag >= one_g_ext) ? mag - one_g_ext : one_g_ext - mag;
   assign sum_in    = sum_ff - SumWidth'(ring_ff[pos_ff]) + SumWidth'(dev);
   assign pos_in    = (pos_ff == PosWidth'(AVG_DEPTH - 1)) ? '0 : pos_ff + PosWidth'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         pos_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.deviate) begin
         ring_ff[pos_ff] <= dev;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // classification, counts and window
   logic [SumWidth-1:0]   rest_scaled, run_scaled;
   activity_type          activity_in, activity_ff;
   logic [CountWidth-1:0] tot_ff, tot_in;
   logic [CountWidth-1:0] act_ff, act_in;
   logic [TimeWidth-1:0]  start_ff;
   logic [TimeWidth-1:0]  elapsed;
   logic                  done_ff;
   logic [PctWidth-1:0]   pct_lhs, pct_rhs;
   logic                  rsp_valid_ff;

   assign rest_scaled = SumWidth'(32'(rest_limit_ff) * 32'(AVG_DEPTH));
   assign run_scaled  = SumWidth'(32'(run_limit_ff) * 32'(AVG_DEPTH));
   assign elapsed     = time_ff - start_ff;

   always_comb begin
      if (sum_ff < rest_scaled) begin
         activity_in = ACT_REST;
      end else if (sum_ff < run_scaled) begin
         activity_in = ACT_WALK;
      end else begin
         activity_in = ACT_RUN;
      end
   end

   always_comb begin
      tot_in = tot_ff;
      act_in = act_ff;
      if (cmd.classify) begin
         if (tot_ff != '1) begin
            tot_in = tot_ff + CountWidth'(1);
         end
         if (activity_in != ACT_REST && act_ff != '1) begin
            act_in = act_ff + CountWidth'(1);
         end
      end else if (cmd.reply && done_ff) begin
         tot_in = '0;
         act_in = '0;
      end
   end

   assign pct_lhs = PctWidth'(act_ff) * PctWidth'(PctScale);
   assign pct_rhs = PctWidth'(active_percent_ff) * PctWidth'(tot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff   <= '0;
         act_ff   <= '0;
         start_ff <= '0;
      end else begin
         tot_ff <= tot_in;
         act_ff <= act_in;
         if (cmd.reply && done_ff) begin
            start_ff <= time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         activity_ff <= activity_in;
         done_ff     <= (elapsed >= window_ms_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_activity      <= activity_ff;
         rsp_window_done   <= done_ff;
         rsp_window_active <= done_ff && (pct_lhs >= pct_rhs);
         rsp_active_count  <= act_ff;
         rsp_total_count   <= tot_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== rtl/accel_activity_classifier.sv =====
// channel   ports                                        direction
// req       req_valid req_stall req_accel_x/y/z time_ms  in
// rsp       rsp_valid rsp_stall rsp_activity ... count   out
// csr       csr_write csr_index csr_data                 in
//
// a beat is accepted only in idle and then passes through load, squaring of x, y and z on
// one shared multiplier, the 16-step bit-serial square root, deviate, classify and reply
// synchronous active-high reset clears the ring, sum, counts and window start
// registers return to their default values on reset
// the result register holds a beat under rsp_stall; the next beat is taken meanwhile
// and waits in its final cycle until the result register frees
module accel_activity_classifier #(
   parameter int AVG_DEPTH = aac_pkg::AvgDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_accel_x,
   input  logic signed [15:0]                req_accel_y,
   input  logic signed [15:0]                req_accel_z,
   input  logic [31:0]                       req_time_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_activity,
   output logic                              rsp_window_done,
   output logic                              rsp_window_active,
   output logic [15:0]                       rsp_active_count,
   output logic [15:0]                       rsp_total_count,
   input  logic                              csr_write,
   input  logic [aac_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [aac_pkg::CsrDataWidth-1:0]  csr_data
);
   import aac_pkg::*;

   cmd_type    cmd;
   status_type status;

   aac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aac_datapath #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_time_ms       (req_time_ms),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_activity      (rsp_activity),
      .rsp_window_done   (rsp_window_done),
      .rsp_window_active (rsp_window_active),
      .rsp_active_count  (rsp_active_count),
      .rsp_total_count   (rsp_total_count)
   );

endmodule

// ===== test/aac_checker.sv =====
module aac_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [15:0]                req_accel_x,
   input  logic signed [15:0]                req_accel_y,
   input  logic signed [15:0]                req_accel_z,
   input  logic [31:0]                       req_time_ms,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_activity,
   input  logic                              rsp_window_done,
   input  logic                              rsp_window_active,
   input  logic [15:0]                       rsp_active_count,
   input  logic [15:0]                       rsp_total_count,
   input  logic                              csr_write,
   input  logic [aac_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [aac_pkg::CsrDataWidth-1:0]  csr_data,
   output int unsigned                       mismatch_count,
   output int unsigned                       outstanding,
   output int unsigned                       beats_checked,
   output int unsigned                       windows_closed,
   output int unsigned                       rest_seen,
   output int unsigned                       walk_seen,
   output int unsigned                       run_seen
);
   import aac_pkg::*;

   localparam int Depth = AvgDepthDefault;
   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [1:0]  activity;
      logic        window_done;
      logic        window_active;
      logic [15:0] active_count;
      logic [15:0] total_count;
   } sample_result_type;

   logic [14:0] one_g;
   logic [15:0] rest_limit;
   logic [15:0] run_limit;
   logic [31:0] window_ms;
   logic [6:0]  active_percent;

   logic [15:0] deviation_ring [Depth];
   int unsigned ring_slot;
   logic [19:0] deviation_total;
   logic [15:0] window_samples;
   logic [15:0] window_active_samples;
   logic [31:0] window_opened;

   sample_result_type predicted_results [$];
   int unsigned n_mismatch = 0;
   int unsigned n_checked = 0;
   int unsigned n_windows = 0;
   int unsigned n_rest = 0;
   int unsigned n_walk = 0;
   int unsigned n_run = 0;

   function automatic logic [15:0] floor_root(input logic [31:0] value);
      logic [31:0] rem;
      logic [31:0] root;
      logic [31:0] step;
      rem  = value;
      root = '0;
      step = 32'h4000_0000;
      while (step > rem) step = step >> 2;
      while (step != 0) begin
         if (rem >= root + step) begin
            rem  = rem - (root + step);
            root = (root >> 1) + step;
         end else begin
            root = root >> 1;
         end
         step = step >> 2;
      end
      return root[15:0];
   endfunction

   function automatic sample_result_type classify_sample(input logic signed [15:0] ax,
                                                         input logic signed [15:0] ay,
                                                         input logic signed [15:0] az,
                                                         input logic [31:0] stamp);
      sample_result_type r;
      int sx;
      int sy;
      int sz;
      logic [31:0] energy;
      logic [31:0] elapsed;
      logic [15:0] magnitude;
      logic [15:0] deviation;
      longint unsigned share;
      longint unsigned needed;
      sx = ax;
      sy = ay;
      sz = az;
      energy = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
      magnitude = floor_root(energy);
      deviation = (magnitude >= {1'b0, one_g}) ? magnitude - {1'b0, one_g}
                                                : {1'b0, one_g} - magnitude;
      deviation_total = deviation_total - 20'(deviation_ring[ring_slot]) + 20'(deviation);
      deviation_ring[ring_slot] = deviation;
      ring_slot = (ring_slot == Depth - 1) ? 0 : ring_slot + 1;

      if (32'(deviation_total) < 32'(rest_limit) * Depth) r.activity = ACT_REST;
      else if (32'(deviation_total) < 32'(run_limit) * Depth) r.activity = ACT_WALK;
      else r.activity = ACT_RUN;

      if (window_samples != 16'hFFFF) window_samples = window_samples + 16'd1;
      if (r.activity != ACT_REST && window_active_samples != 16'hFFFF)
         window_active_samples = window_active_samples + 16'd1;

      r.active_count  = window_active_samples;
      r.total_count   = window_samples;
      r.window_done   = 1'b0;
      r.window_active = 1'b0;

      elapsed = stamp - window_opened;
      if (elapsed >= window_ms) begin
         share  = longint'(r.active_count) * PctScale;
         needed = longint'(active_percent) * longint'(r.total_count);
         r.window_done   = 1'b1;
         r.window_active = (share >= needed);
         window_opened         = stamp;
         window_samples        = '0;
         window_active_samples = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      sample_result_type want;
      sample_result_type got;
      if (reset) begin
         one_g          = OneGReset;
         rest_limit     = RestLimitReset;
         run_limit      = RunLimitReset;
         window_ms      = WindowMsReset;
         active_percent = ActivePercentReset;
         foreach (deviation_ring[i]) deviation_ring[i] = '0;
         ring_slot             = 0;
         deviation_total       = '0;
         window_samples        = '0;
         window_active_samples = '0;
         window_opened         = '0;
         predicted_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ONE_G:          one_g          = csr_data[14:0];
               CSR_REST_LIMIT:     rest_limit     = csr_data[15:0];
               CSR_RUN_LIMIT:      run_limit      = csr_data[15:0];
               CSR_WINDOW_MS:      window_ms      = csr_data[31:0];
               CSR_ACTIVE_PERCENT: active_percent = csr_data[6:0];
               default: ;
            endcase
         end

         // result side first so a beat never meets the sample taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_activity, rsp_window_done, rsp_window_active,
                   rsp_active_count, rsp_total_count};
            if (predicted_results.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= ReportLimit)
                  $display("result beat with nothing outstanding: act %0d done %0b win %0b",
                           got.activity, got.window_done, got.window_active);
            end else begin
               want = predicted_results.pop_front();
               n_checked++;
               if (want.window_done) n_windows++;
               case (want.activity)
                  ACT_REST: n_rest++;
                  ACT_WALK: n_walk++;
                  ACT_RUN:  n_run++;
                  default: ;
               endcase
               if (got !== want) begin
                  n_mismatch++;
                  if (n_mismatch <= ReportLimit) begin
                     $display("mismatch on result %0d: want act %0d done %0b win %0b",
                              n_checked, want.activity, want.window_done,
                              want.window_active);
                     $display("   want act %0d tot %0d",
                              want.active_count, want.total_count);
                     $display("   got act %0d done %0b win %0b act %0d tot %0d",
                              got.activity, got.window_done, got.window_active,
                              got.active_count, got.total_count);
                  end
               end
            end
         end

         if (req_valid && !req_stall)
            predicted_results.push_back(classify_sample(req_accel_x, req_accel_y,
                                                        req_accel_z, req_time_ms));
      end
      mismatch_count <= n_mismatch;
      outstanding    <= predicted_results.size();
      beats_checked  <= n_checked;
      windows_closed <= n_windows;
      rest_seen      <= n_rest;
      walk_seen      <= n_walk;
      run_seen       <= n_run;
   end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import aac_pkg::*;

   localparam int HalfPeriod     = 5;
   localparam int ResetCycles    = 5;
   localparam int PressureCycles = 300;
   localparam int RandomPhases   = 8;
   localparam int BeatsPerPhase  = 160;
   localparam int PressurePhase  = 2;
   localparam int SettleCycles   = 30;
   localparam int FirstSpareIndex = int'(CSR_ACTIVE_PERCENT) + 1;
   localparam int LastIndex       = (1 << CsrIndexWidth) - 1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [15:0]        req_accel_x = '0;
   logic signed [15:0]        req_accel_y = '0;
   logic signed [15:0]        req_accel_z = '0;
   logic [31:0]               req_time_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_activity;
   logic                      rsp_window_done;
   logic                      rsp_window_active;
   logic [15:0]               rsp_active_count;
   logic [15:0]               rsp_total_count;
   logic                      csr_write = 1'b0;
   logic [CsrIndexWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0]   csr_data = '0;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned beats_checked;
   int unsigned windows_closed;
   int unsigned rest_seen;
   int unsigned walk_seen;
   int unsigned run_seen;

   logic        pressure_req = 1'b0;
   logic        rsp_busy = 1'b0;
   logic [31:0] clock_ms = '0;
   int unsigned samples_sent = 0;
   int unsigned settings_used = 1;

   accel_activity_classifier dut (.*);

   aac_checker u_checker (.*);

   always #HalfPeriod clock = ~clock;

   initial begin : watchdog
      #(10_000_000);
      $display("accel_activity_classifier verification failed");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 15);
      return $urandom_range(30, 60);
   endfunction

   function automatic logic signed [15:0] shake(input int centre, input int amp);
      int v;
      v = centre + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az, input logic [31:0] stamp,
                              input bit may_idle);
      int gap;
      if (may_idle && $urandom_range(0, 2) == 0) begin
         gap = idle_cycles();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_time_ms <= stamp;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic send_motion(input int g_level, input int amp, input bit may_idle);
      int centre [3];
      int lane;
      centre = '{0, 0, 0};
      lane = $urandom_range(int'(AXIS_X), int'(AXIS_Z));
      centre[lane] = $urandom_range(0, 1) ? g_level : -g_level;
      clock_ms = clock_ms + $urandom_range(150, 250);
      send_sample(shake(centre[0], amp), shake(centre[1], amp), shake(centre[2], amp),
                  clock_ms, may_idle);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic program_settings(input logic [31:0] g, input logic [31:0] rest,
                                   input logic [31:0] run, input logic [31:0] win,
                                   input logic [31:0] pct);
      csr_index_type order [5];
      logic [31:0] vals [5];
      logic [31:0] masks [5];
      order = '{CSR_ONE_G, CSR_REST_LIMIT, CSR_RUN_LIMIT, CSR_WINDOW_MS, CSR_ACTIVE_PERCENT};
      vals  = '{g, rest, run, win, pct};
      masks = '{32'h0000_7FFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_007F};
      // unused upper bits carry junk
      for (int i = 0; i < 5; i++) begin
         csr_write <= 1'b1;
         csr_index <= order[i];
         csr_data  <= (vals[i] & masks[i]) | ($urandom() & ~masks[i]);
         @(posedge clock);
      end
      csr_write <= 1'b1;
      csr_index <= CsrIndexWidth'($urandom_range(FirstSpareIndex, LastIndex));
      csr_data  <= $urandom();
      @(posedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   initial begin : result_side
      int hold;
      bit pressure_taken;
      pressure_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_req && !pressure_taken) begin
            pressure_taken = 1'b1;
            rsp_stall    <= 1'b1;
            repeat (PressureCycles) @(posedge clock);
            rsp_stall    <= 1'b0;
         end else if (rsp_busy && $urandom_range(0, 2) == 0) begin
            hold = idle_cycles();
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int g;
      int amp;
      int burst;
      int r;
      bit quiet;
      bit may_idle;
      logic [31:0] rest;
      logic [31:0] run;
      logic [31:0] win;
      logic [31:0] pct;
      logic [31:0] stamp;

      repeat (ResetCycles) @(posedge clock);
      reset    <= 1'b0;
      rsp_busy <= 1'b1;

      // register defaults
      send_sample(0, 0, 0, 32'd0, 1'b1);
      send_sample(8192, 0, 0, 32'd200, 1'b1);
      send_sample(-8192, 0, 0, 32'd400, 1'b1);
      send_sample(0, -8192, 0, 32'd600, 1'b1);
      send_sample(0, 0, 8192, 32'd800, 1'b1);
      send_sample(32767, 32767, 32767, 32'd1000, 1'b1);
      send_sample(-32768, -32768, -32768, 32'd1200, 1'b1);
      send_sample(-32768, 32767, 0, 32'd1400, 1'b1);
      send_sample(21845, -21846, 4096, 32'd1600, 1'b1);
      send_sample(16384, 0, 0, 32'd1800, 1'b1);
      send_sample(0, 0, -24576, 32'd299999, 1'b1);
      send_sample(0, 0, 8192, 32'd300000, 1'b1);
      send_sample(0, 8192, 0, 32'd300001, 1'b1);
      send_sample(8192, 0, 0, 32'hFFFF_FFFF, 1'b1);
      send_sample(8192, 0, 0, 32'd5, 1'b1);

      // zero one g, rest limit over run limit, zero window, percent beyond 100
      drain();
      program_settings(32'd0, 32'd65535, 32'd0, 32'd0, 32'd127);
      send_sample(0, 0, 0, 32'd10, 1'b1);
      send_sample(32767, -32768, 1, 32'd20, 1'b1);
      send_sample(100, -100, 50, 32'd20, 1'b1);

      // longest window, only closed by a timestamp one behind the start
      drain();
      program_settings(32'd16384, 32'd0, 32'd65535, 32'hFFFF_FFFF, 32'd0);
      send_sample(16384, 0, 0, 32'd1000, 1'b1);
      send_sample(0, 16384, 0, 32'd19, 1'b1);
      send_sample(-16384, 0, 0, 32'd18, 1'b1);

      clock_ms = 32'd18;
      for (int p = 0; p < RandomPhases; p++) begin
         drain();
         r = $urandom_range(0, 19);
         if (r < 14) g = int'(OneGReset);
         else if (r == 14) g = 32767;
         else g = $urandom_range(1, 16384);
         rest = ($urandom_range(0, 4) != 0) ? $urandom_range(300, 1500) : $urandom_range(0, 65535);
         run  = ($urandom_range(0, 4) != 0) ? $urandom_range(2000, 6000) : $urandom_range(0, 65535);
         r = $urandom_range(0, 19);
         if (r < 14) win = $urandom_range(1000, 6000);
         else if (r < 17) win = $urandom_range(0, 3);
         else win = $urandom();
         pct = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 100) : $urandom_range(101, 127);
         program_settings(g, rest, run, win, pct);

         quiet    = (p % 4 == 1);
         may_idle = !quiet && p != PressurePhase;
         rsp_busy <= !quiet;
         if (p == PressurePhase) pressure_req <= 1'b1;

         burst = 0;
         amp   = 0;
         for (int k = 0; k < BeatsPerPhase; k++) begin
            if (burst == 0) begin
               burst = $urandom_range(8, 40);
               case ($urandom_range(0, 2))
                  0:       amp = g / 40;
                  1:       amp = g / 4;
                  default: amp = g;
               endcase
            end
            burst--;
            if ($urandom_range(0, 99) < 12) begin
               stamp = $urandom_range(0, 1) ? $urandom() : clock_ms - $urandom_range(0, 1000);
               send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()), stamp, may_idle);
            end else begin
               send_motion(g, amp, may_idle);
            end
         end
      end

      drain();
      repeat (SettleCycles) @(posedge clock);
      $display("%0d samples under %0d register settings, %0d results compared",
               samples_sent, settings_used, beats_checked);
      $display("%0d windows closed; classes rest %0d, walk %0d, run %0d",
               windows_closed, rest_seen, walk_seen, run_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("accel_activity_classifier verification clean");
      end else begin
         $display("accel_activity_classifier verification failed");
      end
      $finish;
   end

endmodule
